### hdl/multi_lead_biquad_notch_filter_unit_macros.svh
// Assertion macros shared by the notch filter RTL.
`ifndef MULTI_LEAD_BIQUAD_NOTCH_FILTER_UNIT_MACROS_SVH
`define MULTI_LEAD_BIQUAD_NOTCH_FILTER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clock, quiet during reset.
`define MLBNF_CHECK_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, quiet during reset.
`define MLBNF_CHECK_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/mlbnf_pkg.sv
// Types and constants of the multi-lead notch filter.
`default_nettype none

package mlbnf_pkg;

   localparam int SAMPLE_W  = 24;
   localparam int COEF_FRAC = 16;
   localparam int COEF_W    = 19;
   localparam int LEAD_W    = 4;
   localparam int HIST_W    = SAMPLE_W + COEF_FRAC + 2;
   localparam int NUM_COEF  = 5;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_COEF_A0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_A1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_A2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_B1 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_B2 = 3'd4;

   localparam logic signed [COEF_W-1:0] COEF_A0_RESET = 19'sd62033;
   localparam logic signed [COEF_W-1:0] COEF_A1_RESET = -19'sd90470;
   localparam logic signed [COEF_W-1:0] COEF_A2_RESET = 19'sd62033;
   localparam logic signed [COEF_W-1:0] COEF_B1_RESET = -19'sd93234;
   localparam logic signed [COEF_W-1:0] COEF_B2_RESET = 19'sd62322;

   typedef struct packed {
      logic                       mode;
      logic [LEAD_W-1:0]          lead;
      logic signed [SAMPLE_W-1:0] sample;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] filtered;
      logic                       clipped;
   } rsp_type;

   // Per-lead history: two past inputs, two past wide outputs.
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] x1;
      logic signed [SAMPLE_W-1:0] x2;
      logic signed [HIST_W-1:0]   y1;
      logic signed [HIST_W-1:0]   y2;
   } hist_type;

   typedef struct packed {
      logic              en;
      logic              clear;
      logic [LEAD_W-1:0] lead;
   } hist_wr_type;

endpackage

`default_nettype wire

### hdl/mlbnf_hist.sv
// Per-lead history store with valid bits and write-to-read bypass.
`default_nettype none

module mlbnf_hist #(
   parameter int LEADS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               rd_en,
   input  logic [mlbnf_pkg::LEAD_W-1:0]       rd_lead,
   output mlbnf_pkg::hist_type                rd_hist,
   input  mlbnf_pkg::hist_wr_type             wr,
   input  mlbnf_pkg::hist_type                wr_hist
);

   localparam int ADDR_W     = (LEADS > 1) ? $clog2(LEADS) : 1;
   localparam int LEAD_EXT_W = 7;

   mlbnf_pkg::hist_type mem_ff [LEADS];
   logic [LEADS-1:0]    vld_ff;

   mlbnf_pkg::hist_type rd_mem_ff;
   mlbnf_pkg::hist_type byp_data_ff;
   logic                rd_vld_ff;
   logic                byp_ff;

   logic [LEAD_EXT_W-1:0] rd_lead_ext;
   logic [LEAD_EXT_W-1:0] wr_lead_ext;
   logic [ADDR_W-1:0]     rd_idx;
   logic [ADDR_W-1:0]     wr_idx;
   logic                  hit;

   assign rd_lead_ext = LEAD_EXT_W'(rd_lead);
   assign wr_lead_ext = LEAD_EXT_W'(wr.lead);
   assign rd_idx      = rd_lead_ext[ADDR_W-1:0];
   assign wr_idx      = wr_lead_ext[ADDR_W-1:0];
   assign hit         = wr.en && (wr_idx == rd_idx);

   always_ff @(posedge clock) begin
      if (wr.en && !wr.clear) begin
         mem_ff[wr_idx] <= wr_hist;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_mem_ff   <= mem_ff[rd_idx];
         byp_data_ff <= wr.clear ? '0 : wr_hist;
      end
   end

   // A cleared lead simply loses its valid bit and reads back as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
         byp_ff    <= 1'b0;
      end else begin
         if (wr.en) begin
            vld_ff[wr_idx] <= !wr.clear;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_idx];
            byp_ff    <= hit;
         end
      end
   end

   assign rd_hist = byp_ff ? byp_data_ff : (rd_vld_ff ? rd_mem_ff : '0);

endmodule

`default_nettype wire

### hdl/multi_lead_biquad_notch_filter_unit.sv
// Top level of the multi-lead direct-form-1 biquad notch filter.
//
// Usage:
//   req_*  : valid/ready channel carrying {mode, lead, sample}. mode 0 filters the
//            sample with the lead's history, mode 1 clears that history.
//   rsp_*  : valid/ready channel carrying {filtered, clipped}, one per transaction,
//            in order. Clear requests and leads beyond LEADS return zero.
//   csr_*  : write-only port for coef_a0, coef_a1, coef_a2, coef_b1, coef_b2
//            (indices 0..4); write only while the filter is empty.
// Timing:
//   Three stages: history read and products, accumulate and saturate, result
//   register. rsp_valid follows acceptance through the stage 1, stage 2 and
//   result registers. Different leads stream at one transaction per cycle while
//   rsp_ready is high; a transaction for the same lead as one in stage 1, or held in
//   stage 2, waits for the y1 feedback through the history before it is accepted.
// Reset: coefficients return to their defaults, every lead's history reads as
//   zero, the pipeline empties. No clearing pass is needed.
// Stall: while rsp_ready is low the result holds and the stages behind it fill,
//   then req_ready drops.
`default_nettype none

`include "multi_lead_biquad_notch_filter_unit_macros.svh"

module multi_lead_biquad_notch_filter_unit #(
   parameter int LEADS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  mlbnf_pkg::req_type                   req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output mlbnf_pkg::rsp_type                   rsp_data,
   input  logic                                 csr_wr_en,
   input  logic [mlbnf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mlbnf_pkg::COEF_W-1:0]         csr_wdata
);

   localparam int SW     = mlbnf_pkg::SAMPLE_W;
   localparam int F      = mlbnf_pkg::COEF_FRAC;
   localparam int HW     = mlbnf_pkg::HIST_W;
   localparam int CW     = mlbnf_pkg::COEF_W;
   localparam int YL_W   = HW / 2;
   localparam int YH_W   = HW - YL_W;
   localparam int PX_W   = CW + SW;
   localparam int PH_W   = CW + YH_W;
   localparam int PL_W   = CW + YL_W + 1;
   localparam int FF_W   = PX_W + 2;
   localparam int ACC_W  = HW + CW + 2;
   localparam int LCMP_W = 7;

   localparam logic [LCMP_W-1:0]    LEADS_V = LCMP_W'(LEADS);
   localparam logic signed [HW-1:0] RND     = HW'((64'sd1 <<< F) - 64'sd1);
   localparam logic signed [HW-1:0] ZERO_H  = '0;

   // ---------------- coefficients ----------------
   logic signed [CW-1:0] coef_a0_ff, coef_a1_ff, coef_a2_ff, coef_b1_ff, coef_b2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_a0_ff <= mlbnf_pkg::COEF_A0_RESET;
         coef_a1_ff <= mlbnf_pkg::COEF_A1_RESET;
         coef_a2_ff <= mlbnf_pkg::COEF_A2_RESET;
         coef_b1_ff <= mlbnf_pkg::COEF_B1_RESET;
         coef_b2_ff <= mlbnf_pkg::COEF_B2_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            mlbnf_pkg::CSR_COEF_A0: coef_a0_ff <= $signed(csr_wdata);
            mlbnf_pkg::CSR_COEF_A1: coef_a1_ff <= $signed(csr_wdata);
            mlbnf_pkg::CSR_COEF_A2: coef_a2_ff <= $signed(csr_wdata);
            mlbnf_pkg::CSR_COEF_B1: coef_b1_ff <= $signed(csr_wdata);
            mlbnf_pkg::CSR_COEF_B2: coef_b2_ff <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   // ---------------- handshake and hazards ----------------
   logic               s1_vld_ff, s2_vld_ff, rsp_vld_ff;
   mlbnf_pkg::req_type s1_item_ff, s2_item_ff;
   logic               s1_ok_ff, s2_ok_ff;
   mlbnf_pkg::rsp_type rsp_data_ff;

   logic out_free, s2_fire, s2_free, s1_free, accept, hazard, req_ok;

   assign out_free = !rsp_vld_ff || rsp_ready;
   assign s2_fire  = s2_vld_ff && out_free;
   assign s2_free  = !s2_vld_ff || out_free;
   assign s1_free  = !s1_vld_ff || s2_free;

   // Hold a transaction whose lead still has an older one waiting to write back.
   assign hazard = (s1_vld_ff && (s1_item_ff.lead == req_data.lead)) ||
                   (s2_vld_ff && !out_free && (s2_item_ff.lead == req_data.lead));

   assign req_ready = s1_free && !hazard;
   assign accept    = req_valid && req_ready;
   assign req_ok    = LCMP_W'(req_data.lead) < LEADS_V;

   // ---------------- history store ----------------
   mlbnf_pkg::hist_type    rd_hist;
   mlbnf_pkg::hist_type    wr_hist;
   mlbnf_pkg::hist_wr_type wr;

   mlbnf_hist #(.LEADS(LEADS)) u_hist (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept && req_ok),
      .rd_lead (req_data.lead),
      .rd_hist (rd_hist),
      .wr      (wr),
      .wr_hist (wr_hist)
   );

   // ---------------- stage 1: products ----------------
   logic signed [PX_W-1:0] pa0_in, pa1_in, pa2_in;
   logic signed [PH_W-1:0] pb1h_in, pb2h_in;
   logic signed [PL_W-1:0] pb1l_in, pb2l_in;

   always_comb begin
      pa0_in  = PX_W'(coef_a0_ff) * PX_W'(s1_item_ff.sample);
      pa1_in  = PX_W'(coef_a1_ff) * PX_W'(rd_hist.x1);
      pa2_in  = PX_W'(coef_a2_ff) * PX_W'(rd_hist.x2);
      // Split the wide outputs into a signed upper and an unsigned lower half.
      pb1h_in = PH_W'(coef_b1_ff) * PH_W'($signed(rd_hist.y1[HW-1:YL_W]));
      pb1l_in = PL_W'(coef_b1_ff) * PL_W'($signed({1'b0, rd_hist.y1[YL_W-1:0]}));
      pb2h_in = PH_W'(coef_b2_ff) * PH_W'($signed(rd_hist.y2[HW-1:YL_W]));
      pb2l_in = PL_W'(coef_b2_ff) * PL_W'($signed({1'b0, rd_hist.y2[YL_W-1:0]}));
   end

   logic signed [PX_W-1:0] pa0_ff, pa1_ff, pa2_ff;
   logic signed [PH_W-1:0] pb1h_ff, pb2h_ff;
   logic signed [PL_W-1:0] pb1l_ff, pb2l_ff;
   logic signed [SW-1:0]   s2_x1_ff;
   logic signed [HW-1:0]   s2_y1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (s1_free) begin
            s1_vld_ff <= accept;
         end
         if (s2_free) begin
            s2_vld_ff <= s1_vld_ff;
         end
         if (out_free) begin
            rsp_vld_ff <= s2_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= req_data;
         s1_ok_ff   <= req_ok;
      end
      if (s1_vld_ff && s2_free) begin
         s2_item_ff <= s1_item_ff;
         s2_ok_ff   <= s1_ok_ff;
         s2_x1_ff   <= rd_hist.x1;
         s2_y1_ff   <= rd_hist.y1;
         pa0_ff     <= pa0_in;
         pa1_ff     <= pa1_in;
         pa2_ff     <= pa2_in;
         pb1h_ff    <= pb1h_in;
         pb1l_ff    <= pb1l_in;
         pb2h_ff    <= pb2h_in;
         pb2l_ff    <= pb2l_in;
      end
   end

   // ---------------- stage 2: accumulate, floor, saturate ----------------
   logic signed [FF_W-1:0]  ff_sum;
   logic signed [ACC_W-1:0] fb1, fb2, acc, y0w;
   logic                    y0_ovf, out_ovf;
   logic signed [HW-1:0]    y0, rnd_add, yr, yt;
   logic signed [SW-1:0]    filt;

   always_comb begin
      ff_sum  = FF_W'(pa0_ff) + FF_W'(pa1_ff) + FF_W'(pa2_ff);
      fb1     = (ACC_W'(pb1h_ff) <<< YL_W) + ACC_W'(pb1l_ff);
      fb2     = (ACC_W'(pb2h_ff) <<< YL_W) + ACC_W'(pb2l_ff);
      acc     = (ACC_W'(ff_sum) <<< F) - fb1 - fb2;
      y0w     = acc >>> F;
      y0_ovf  = y0w[ACC_W-1:HW-1] != {(ACC_W-HW+1){y0w[ACC_W-1]}};
      y0      = y0_ovf ? {y0w[ACC_W-1], {(HW-1){~y0w[ACC_W-1]}}} : y0w[HW-1:0];
      // Truncate toward zero: bias negatives before the arithmetic shift.
      rnd_add = y0[HW-1] ? RND : ZERO_H;
      yr      = y0 + rnd_add;
      yt      = yr >>> F;
      out_ovf = yt[HW-1:SW-1] != {(HW-SW+1){yt[HW-1]}};
      filt    = out_ovf ? {yt[HW-1], {(SW-1){~yt[HW-1]}}} : yt[SW-1:0];
   end

   assign wr.en    = s2_fire && s2_ok_ff;
   assign wr.clear = s2_item_ff.mode;
   assign wr.lead  = s2_item_ff.lead;

   assign wr_hist.x1 = s2_item_ff.sample;
   assign wr_hist.x2 = s2_x1_ff;
   assign wr_hist.y1 = y0;
   assign wr_hist.y2 = s2_y1_ff;

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (s2_fire) begin
         if (s2_ok_ff && !s2_item_ff.mode) begin
            rsp_data_ff.filtered <= filt;
            rsp_data_ff.clipped  <= out_ovf;
         end else begin
            rsp_data_ff <= '0;
         end
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------- assertions ----------------
   logic s12_vld, s2_skip;

   assign s12_vld = s1_vld_ff && s2_vld_ff;
   assign s2_skip = s2_fire && (!s2_ok_ff || s2_item_ff.mode);

   `MLBNF_CHECK_NOW(a_lead_apart, s12_vld, s1_item_ff.lead != s2_item_ff.lead, "lead in flight twice")
   `MLBNF_CHECK_NEXT(a_skip_zero, s2_skip, rsp_data_ff == '0, "skipped transaction not zero")
   `MLBNF_CHECK_NEXT(a_accept_lands, accept, s1_vld_ff, "accepted transaction lost")

endmodule

`default_nettype wire

### bench/tb_multi_lead_biquad_notch_filter_unit.sv
// Self-checking testbench for the multi-lead biquad notch filter unit.
module tb_multi_lead_biquad_notch_filter_unit;
   import mlbnf_pkg::*;

   localparam int LEAD_COUNT  = 16;
   localparam int SAMPLE_MAX  = (1 << (SAMPLE_W - 1)) - 1;
   localparam int SAMPLE_MIN  = -(1 << (SAMPLE_W - 1));
   localparam int COEF_MAX    = (1 << (COEF_W - 1)) - 1;
   localparam int COEF_MIN    = -(1 << (COEF_W - 1));
   localparam int CYCLE_LIMIT = 200000;
   localparam int REPORT_MAX  = 10;

   localparam logic MODE_FILTER = 1'b0;
   localparam logic MODE_CLEAR  = 1'b1;

   localparam longint WIDE_MAX = (longint'(1) <<< (HIST_W - 1)) - 1;
   localparam longint WIDE_MIN = -(longint'(1) <<< (HIST_W - 1));
   localparam longint OUT_MAX  = SAMPLE_MAX;
   localparam longint OUT_MIN  = SAMPLE_MIN;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [COEF_W-1:0]    csr_wdata = '0;

   // Filter state as the unit should hold it
   logic signed [COEF_W-1:0]   coef_model [NUM_COEF];
   logic signed [SAMPLE_W-1:0] past_x1 [LEAD_COUNT];
   logic signed [SAMPLE_W-1:0] past_x2 [LEAD_COUNT];
   logic signed [HIST_W-1:0]   past_y1 [LEAD_COUNT];
   logic signed [HIST_W-1:0]   past_y2 [LEAD_COUNT];

   rsp_type pending_outputs [$];
   int      fail_count    = 0;
   int      cycle_count   = 0;
   int      send_idle_pct = 27;
   int      recv_idle_pct = 84;

   multi_lead_biquad_notch_filter_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic int rand_in(int lo, int hi);
      return lo + int'($urandom_range(hi - lo));
   endfunction

   // Advance or clear one lead's biquad; return the filtered, saturated output.
   function automatic rsp_type notch_predict(req_type item);
      rsp_type res;
      longint  ff, acc, y0, whole;
      res = '0;
      if (int'(item.lead) >= LEAD_COUNT)
         return res;
      if (item.mode == MODE_CLEAR) begin
         past_x1[item.lead] = '0;
         past_x2[item.lead] = '0;
         past_y1[item.lead] = '0;
         past_y2[item.lead] = '0;
         return res;
      end
      ff = longint'(coef_model[0]) * longint'(item.sample)
         + longint'(coef_model[1]) * longint'(past_x1[item.lead])
         + longint'(coef_model[2]) * longint'(past_x2[item.lead]);
      acc = (ff <<< COEF_FRAC)
          - longint'(coef_model[3]) * longint'(past_y1[item.lead])
          - longint'(coef_model[4]) * longint'(past_y2[item.lead]);
      y0 = acc >>> COEF_FRAC;
      if (y0 > WIDE_MAX)
         y0 = WIDE_MAX;
      else if (y0 < WIDE_MIN)
         y0 = WIDE_MIN;
      past_x2[item.lead] = past_x1[item.lead];
      past_x1[item.lead] = item.sample;
      past_y2[item.lead] = past_y1[item.lead];
      past_y1[item.lead] = y0[HIST_W-1:0];
      // truncate toward zero, not toward minus infinity
      whole = (y0 < 0) ? -((-y0) >>> COEF_FRAC) : (y0 >>> COEF_FRAC);
      if (whole > OUT_MAX) begin
         whole       = OUT_MAX;
         res.clipped = 1'b1;
      end else if (whole < OUT_MIN) begin
         whole       = OUT_MIN;
         res.clipped = 1'b1;
      end
      res.filtered = whole[SAMPLE_W-1:0];
      return res;
   endfunction

   task automatic send_sample(input logic mode, input int lead, input int sample);
      req_type item;
      item.mode   = mode;
      item.lead   = lead[LEAD_W-1:0];
      item.sample = sample[SAMPLE_W-1:0];
      @(negedge clock);
      while (rand_in(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      pending_outputs.push_back(notch_predict(item));
   endtask

   // Drop valid and hold until every outstanding transaction has returned.
   task automatic drain_filter();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_outputs.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_coefs(input int a0, input int a1, input int a2,
                              input int b1, input int b2);
      logic [CSR_IDX_W-1:0] regs [NUM_COEF];
      int                   vals [NUM_COEF];
      regs = '{CSR_COEF_A0, CSR_COEF_A1, CSR_COEF_A2, CSR_COEF_B1, CSR_COEF_B2};
      vals = '{a0, a1, a2, b1, b2};
      for (int i = 0; i < NUM_COEF; i++) begin
         @(negedge clock);
         csr_wr_en <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= vals[i][COEF_W-1:0];
         @(posedge clock);
         coef_model[regs[i]] = vals[i][COEF_W-1:0];
      end
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic write_random_coefs(input int fb_span);
      write_coefs(rand_in(COEF_MIN, COEF_MAX), rand_in(COEF_MIN, COEF_MAX),
                  rand_in(COEF_MIN, COEF_MAX), rand_in(-fb_span, fb_span),
                  rand_in(-fb_span, fb_span));
   endtask

   task automatic test_default_notch();
      send_sample(MODE_FILTER, 0, SAMPLE_MAX);
      send_sample(MODE_FILTER, 0, SAMPLE_MIN);
      send_sample(MODE_FILTER, 0, SAMPLE_MAX);
      send_sample(MODE_FILTER, 0, 0);
      send_sample(MODE_FILTER, 15, SAMPLE_MIN);
      send_sample(MODE_FILTER, 15, SAMPLE_MIN);
      send_sample(MODE_FILTER, 7, 1);
      send_sample(MODE_FILTER, 7, -1);
   endtask

   task automatic test_history_clear();
      send_sample(MODE_CLEAR, 0, SAMPLE_MAX);
      send_sample(MODE_FILTER, 0, SAMPLE_MAX);
      send_sample(MODE_CLEAR, 15, SAMPLE_MIN);
      send_sample(MODE_FILTER, 15, 12345);
      drain_filter();
   endtask

   // Runaway feedback drives both the wide history and the output into saturation.
   task automatic test_coef_extremes();
      write_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN);
      repeat (5) send_sample(MODE_FILTER, 2, SAMPLE_MAX);
      drain_filter();
      write_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MAX);
      repeat (4) send_sample(MODE_FILTER, 2, SAMPLE_MIN);
      send_sample(MODE_CLEAR, 2, 0);
      drain_filter();
      write_coefs(0, 0, 0, 0, 0);
      send_sample(MODE_FILTER, 9, SAMPLE_MAX);
      send_sample(MODE_FILTER, 9, SAMPLE_MIN);
      drain_filter();
   endtask

   task automatic test_random_stream(input int count);
      int lead = 0;
      int pick;
      int sample;
      for (int n = 0; n < count; n++) begin
         if (rand_in(0, 99) >= 40)
            lead = rand_in(0, LEAD_COUNT - 1);
         pick = rand_in(0, 99);
         if (pick < 55)
            sample = rand_in(-(1 << 16), (1 << 16));
         else if (pick < 85)
            sample = rand_in(SAMPLE_MIN, SAMPLE_MAX);
         else if (pick < 92)
            sample = SAMPLE_MAX;
         else
            sample = SAMPLE_MIN;
         send_sample((rand_in(0, 99) < 4) ? MODE_CLEAR : MODE_FILTER, lead, sample);
      end
      drain_filter();
   endtask

   always @(negedge clock)
      rsp_ready <= (rand_in(0, 99) >= recv_idle_pct);

   always @(posedge clock) begin : check_outputs
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outputs.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
               $display("unexpected transaction: filtered %0d clipped %0b",
                        rsp_data.filtered, rsp_data.clipped);
         end else begin
            want = pending_outputs.pop_front();
            if (rsp_data.filtered !== want.filtered || rsp_data.clipped !== want.clipped) begin
               fail_count++;
               if (fail_count <= REPORT_MAX)
                  $display("mismatch: expected filtered %0d clipped %0b, got %0d %0b",
                           want.filtered, want.clipped, rsp_data.filtered, rsp_data.clipped);
            end
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      coef_model = '{COEF_A0_RESET, COEF_A1_RESET, COEF_A2_RESET,
                     COEF_B1_RESET, COEF_B2_RESET};
      for (int i = 0; i < LEAD_COUNT; i++) begin
         past_x1[i] = '0;
         past_x2[i] = '0;
         past_y1[i] = '0;
         past_y2[i] = '0;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_notch();
      test_history_clear();
      test_coef_extremes();

      // 60 Hz notch, then 50 Hz notch
      write_coefs(int'(COEF_A0_RESET), int'(COEF_A1_RESET), int'(COEF_A2_RESET),
                  int'(COEF_B1_RESET), int'(COEF_B2_RESET));
      test_random_stream(171);
      write_coefs(65849, -106580, 65849, -103472, 62322);
      test_random_stream(171);

      send_idle_pct = 84;
      recv_idle_pct = 27;
      write_random_coefs(COEF_MAX);
      test_random_stream(171);
      write_random_coefs(1 << 15);
      test_random_stream(171);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_coefs(65849, -106580, 65849, -103472, 62322);
      test_random_stream(171);
      write_coefs(COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN);
      test_random_stream(171);

      fail_count += pending_outputs.size();
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
